/* sv/utf8_word_and_bigram_tokenizer_macros.svh */
// Assertion macros used by the port checker of the tokenizer.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef UTF8_WORD_AND_BIGRAM_TOKENIZER_MACROS_SVH
`define UTF8_WORD_AND_BIGRAM_TOKENIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8WBT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8WBT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/u8wbt_pkg.sv */
// Package of the UTF-8 word and bigram tokenizer: widths, class codes and helpers.
// Used by the tokenizer top level, its port checker and the testbench; depends on nothing else.
package u8wbt_pkg;

    localparam int BYTE_W      = 8;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] WORD_NONE = 2'd0;
    localparam logic [1:0] WORD_ONE  = 2'd1;
    localparam logic [1:0] WORD_MANY = 2'd2;

    localparam logic [1:0] RUN_EMPTY = 2'd0;
    localparam logic [1:0] RUN_ONE   = 2'd1;
    localparam logic [1:0] RUN_MANY  = 2'd2;

    localparam logic [7:0] HIGH_BIT_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK    = 8'hE0;
    localparam logic [7:0] LEAD2_CODE    = 8'hC0;
    localparam logic [7:0] LEAD3_MASK    = 8'hF0;
    localparam logic [7:0] LEAD3_CODE    = 8'hE0;
    localparam logic [7:0] LEAD4_MASK    = 8'hF8;
    localparam logic [7:0] LEAD4_CODE    = 8'hF0;

    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef struct packed {
        logic [31:0] cp;
        logic [2:0]  len;
        logic        last_end;
    } cp_seg_t;

    function automatic logic [1:0] lead_extra(input logic [7:0] b);
        logic [1:0] extra;
        extra = 2'd0;
        if ((b & LEAD2_MASK) == LEAD2_CODE) extra = 2'd1;
        else if ((b & LEAD3_MASK) == LEAD3_CODE) extra = 2'd2;
        else if ((b & LEAD4_MASK) == LEAD4_CODE) extra = 2'd3;
        return extra;
    endfunction

    function automatic logic is_upper(input logic [7:0] b);
        return (b >= CHAR_UP_A) && (b <= CHAR_UP_Z);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return ((b >= CHAR_0) && (b <= CHAR_9)) || is_upper(b) ||
               ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z));
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return is_upper(b) ? (b + CASE_OFFSET) : b;
    endfunction

    function automatic logic [7:0] cp_byte(input logic [31:0] cp, input logic [1:0] idx);
        return cp[{idx, 3'b000} +: 8];
    endfunction

endpackage

/* sv/utf8_word_and_bigram_tokenizer.sv */
// A byte's first token word is registered and appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one word and m_tready is high;
// a byte with more words holds the input until its last word leaves, one word per ready cycle.
// Reset (rst_n, asynchronous, active low) clears the word and code point state and empties
// the result buffer; the block accepts a byte in the first cycle after reset.
module utf8_word_and_bigram_tokenizer
    import u8wbt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // in_byte
    input  logic              s_tlast,   // end_of_text
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // out_byte
    output logic              m_tlast,   // token_end
    output logic              m_tuser    // burst_last
);

    logic [7:0]  held_word_reg, held_word_next;
    logic [1:0]  word_class_reg, word_class_next;
    logic [31:0] prev_cp_reg, prev_cp_next;
    logic [2:0]  prev_len_reg, prev_len_next;
    logic [31:0] cur_cp_reg, cur_cp_next;
    logic [2:0]  cur_len_reg, cur_len_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  run_class_reg, run_class_next;

    logic [7:0]  buf_byte_reg [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] buf_end_reg;
    logic [CNT_W-1:0] remain_reg;

    logic        accept;
    logic        beat;
    logic        eot;
    logic [7:0]  in_byte;
    logic [7:0]  lower_byte;
    logic [31:0] grown_cp;
    logic [2:0]  grown_len;
    logic        complete;
    cp_seg_t     comp_seg;
    cp_seg_t     a_seg;
    cp_seg_t     b_seg;
    logic [1:0]  word_cnt;
    logic [7:0]  word_byte0;
    logic [7:0]  word_byte1;
    logic [1:0]  word_end;
    logic [3:0]  total;
    logic [CNT_W-1:0] count;
    logic [8:0]  slot [MAX_RESULTS];

    function automatic logic [8:0] pick_slot(
        input logic [2:0] k,
        input logic [1:0] nw,
        input logic [7:0] w0,
        input logic [7:0] w1,
        input logic [1:0] wend,
        input cp_seg_t    a,
        input cp_seg_t    b
    );
        logic [3:0] j;
        logic [3:0] j2;
        logic [2:0] idx3;
        logic [8:0] res;
        j   = {1'b0, k} - {2'b00, nw};
        j2  = j - {1'b0, a.len};
        res = '0;
        if ({1'b0, k} < {2'b00, nw}) begin
            res = k[0] ? {wend[1], w1} : {wend[0], w0};
        end
        else if (j < {1'b0, a.len}) begin
            idx3 = a.len - 3'd1 - j[2:0];
            res  = {a.last_end && (j == ({1'b0, a.len} - 4'd1)), cp_byte(a.cp, idx3[1:0])};
        end
        else if (j2 < {1'b0, b.len}) begin
            idx3 = b.len - 3'd1 - j2[2:0];
            res  = {b.last_end && (j2 == ({1'b0, b.len} - 4'd1)), cp_byte(b.cp, idx3[1:0])};
        end
        return res;
    endfunction

    assign in_byte    = s_tdata;
    assign eot        = s_tlast;
    assign lower_byte = to_lower(in_byte);
    assign grown_cp   = {cur_cp_reg[23:0], in_byte};
    assign grown_len  = cur_len_reg + 3'd1;

    assign s_tready = (remain_reg == '0) || ((remain_reg == CNT_W'(1)) && m_tready);
    assign accept   = s_tvalid && s_tready;
    assign beat     = m_tvalid && m_tready;

    assign m_tvalid = (remain_reg != '0);
    assign m_tdata  = buf_byte_reg[0];
    assign m_tlast  = buf_end_reg[0];
    assign m_tuser  = (remain_reg == CNT_W'(1));

    always_comb
    begin
        held_word_next  = held_word_reg;
        word_class_next = word_class_reg;
        prev_cp_next    = prev_cp_reg;
        prev_len_next   = prev_len_reg;
        cur_cp_next     = cur_cp_reg;
        cur_len_next    = cur_len_reg;
        need_next       = need_reg;
        run_class_next  = run_class_reg;
        complete        = 1'b0;
        comp_seg        = '0;
        a_seg           = '0;
        b_seg           = '0;
        word_cnt        = 2'd0;
        word_byte0      = held_word_reg;
        word_byte1      = lower_byte;
        word_end        = 2'b00;

        if (need_reg != 2'd0)
        begin
            cur_cp_next   = grown_cp;
            cur_len_next  = grown_len;
            need_next     = need_reg - 2'd1;
            complete      = (need_reg == 2'd1) || eot;
            comp_seg.cp   = grown_cp;
            comp_seg.len  = grown_len;
        end
        else if ((in_byte & HIGH_BIT_MASK) == '0)
        begin
            if (run_class_reg == RUN_ONE)
            begin
                a_seg.cp       = prev_cp_reg;
                a_seg.len      = prev_len_reg;
                a_seg.last_end = 1'b1;
            end
            run_class_next = RUN_EMPTY;
            prev_cp_next   = '0;
            prev_len_next  = '0;
            if (is_alnum(in_byte))
            begin
                held_word_next = lower_byte;
                if (word_class_reg != WORD_NONE)
                begin
                    word_cnt        = eot ? 2'd2 : 2'd1;
                    word_end        = {1'b1, 1'b0};
                    word_class_next = WORD_MANY;
                end
                else
                begin
                    word_class_next = WORD_ONE;
                end
            end
            else
            begin
                if (word_class_reg == WORD_MANY)
                begin
                    word_cnt = 2'd1;
                    word_end = 2'b01;
                end
                word_class_next = WORD_NONE;
                held_word_next  = '0;
            end
        end
        else
        begin
            if (word_class_reg == WORD_MANY)
            begin
                word_cnt = 2'd1;
                word_end = 2'b01;
            end
            word_class_next = WORD_NONE;
            held_word_next  = '0;
            cur_cp_next     = {24'b0, in_byte};
            cur_len_next    = 3'd1;
            need_next       = lead_extra(in_byte);
            complete        = (lead_extra(in_byte) == 2'd0) || eot;
            comp_seg.cp     = {24'b0, in_byte};
            comp_seg.len    = 3'd1;
        end

        if (complete)
        begin
            cur_cp_next   = '0;
            cur_len_next  = '0;
            need_next     = 2'd0;
            prev_cp_next  = comp_seg.cp;
            prev_len_next = comp_seg.len;
            if (run_class_reg == RUN_EMPTY)
            begin
                run_class_next = RUN_ONE;
                if (eot)
                begin
                    a_seg.cp       = comp_seg.cp;
                    a_seg.len      = comp_seg.len;
                    a_seg.last_end = 1'b1;
                end
            end
            else
            begin
                a_seg.cp       = prev_cp_reg;
                a_seg.len      = prev_len_reg;
                a_seg.last_end = 1'b0;
                b_seg.cp       = comp_seg.cp;
                b_seg.len      = comp_seg.len;
                b_seg.last_end = 1'b1;
                run_class_next = RUN_MANY;
            end
        end

        if (eot)
        begin
            held_word_next  = '0;
            word_class_next = WORD_NONE;
            prev_cp_next    = '0;
            prev_len_next   = '0;
            cur_cp_next     = '0;
            cur_len_next    = '0;
            need_next       = 2'd0;
            run_class_next  = RUN_EMPTY;
        end
    end

    always_comb
    begin
        total = {2'b00, word_cnt} + {1'b0, a_seg.len} + {1'b0, b_seg.len};
        count = (total > 4'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(total);
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            slot[k] = pick_slot(3'(k), word_cnt, word_byte0, word_byte1, word_end,
                                a_seg, b_seg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_word_reg  <= '0;
            word_class_reg <= WORD_NONE;
            prev_cp_reg    <= '0;
            prev_len_reg   <= '0;
            cur_cp_reg     <= '0;
            cur_len_reg    <= '0;
            need_reg       <= '0;
            run_class_reg  <= RUN_EMPTY;
            remain_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                held_word_reg  <= held_word_next;
                word_class_reg <= word_class_next;
                prev_cp_reg    <= prev_cp_next;
                prev_len_reg   <= prev_len_next;
                cur_cp_reg     <= cur_cp_next;
                cur_len_reg    <= cur_len_next;
                need_reg       <= need_next;
                run_class_reg  <= run_class_next;
                remain_reg     <= count;
            end
            else if (beat)
            begin
                remain_reg <= remain_reg - CNT_W'(1);
            end
        end
    end

    // The result buffer shifts toward slot 0, which always drives the output.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < MAX_RESULTS; k++)
            begin
                buf_byte_reg[k] <= slot[k][7:0];
                buf_end_reg[k]  <= slot[k][8];
            end
        end
        else if (beat)
        begin
            for (int k = 0; k < MAX_RESULTS - 1; k++)
            begin
                buf_byte_reg[k] <= buf_byte_reg[k+1];
                buf_end_reg[k]  <= buf_end_reg[k+1];
            end
        end
    end

endmodule

/* sv/u8wbt_checker.sv */
// Port checker for the UTF-8 word and bigram tokenizer, bound to its top level.
// Depends on u8wbt_pkg and the macros in utf8_word_and_bigram_tokenizer_macros.svh.
`include "utf8_word_and_bigram_tokenizer_macros.svh"

module u8wbt_checker
    import u8wbt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    `U8WBT_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "output word changed while stalled")

    `U8WBT_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with no word pending")

    `U8WBT_ASSERT_NOW(a_ready_on_last_beat, m_tvalid && m_tready && m_tuser, s_tready, "input stalled while the last word of a burst leaves")

    `U8WBT_ASSERT_NOW(a_hold_inside_burst, m_tvalid && !m_tuser, !s_tready, "byte accepted while a burst still has several words")

endmodule

bind utf8_word_and_bigram_tokenizer u8wbt_checker u_checker (.*);

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_word_and_bigram_tokenizer: streams directed and random texts,
// predicts each token word in a scoreboard class and checks the output stream in order.
// Depends on u8wbt_pkg and the tokenizer RTL only.
module tb_top;
    import u8wbt_pkg::*;

    localparam int WATCHDOG_LIMIT = 200;
    localparam int RANDOM_BYTES   = 156;
    localparam logic [23:0] DIRECTED_EOT = 24'hB00010;

    typedef struct packed {
        logic [7:0] data;
        logic       token_end;
        logic       burst_last;
    } token_word_t;

    class token_stream_scoreboard;
        token_word_t expected_words[$];
        token_word_t burst[$];
        int          failures;
        logic [7:0]  held_byte;
        logic [1:0]  word_state;
        logic [31:0] prev_cp;
        logic [2:0]  prev_len;
        logic [31:0] cur_cp;
        logic [2:0]  cur_len;
        logic [2:0]  pending_cont;
        logic [1:0]  run_state;

        function new();
            failures = 0;
            clear_state();
        endfunction

        function void clear_state();
            held_byte    = 8'd0;
            word_state   = WORD_NONE;
            prev_cp      = 32'd0;
            prev_len     = 3'd0;
            cur_cp       = 32'd0;
            cur_len      = 3'd0;
            pending_cont = 3'd0;
            run_state    = RUN_EMPTY;
        endfunction

        function void emit(logic [7:0] b, logic last_end);
            token_word_t w;
            if (burst.size() < MAX_RESULTS)
            begin
                w.data       = b;
                w.token_end  = last_end;
                w.burst_last = 1'b0;
                burst.insert(burst.size(), w);
            end
        endfunction

        function void emit_code_point(logic [31:0] cp, logic [2:0] len, logic last_end);
            int i;
            if (len > 3'd4)
                len = 3'd4;
            for (i = int'(len) - 1; i >= 0; i--)
                emit(cp[8*i +: 8], last_end && (i == 0));
        endfunction

        function void close_word();
            if (word_state == WORD_MANY)
                emit(held_byte, 1'b1);
            word_state = WORD_NONE;
            held_byte  = 8'd0;
        endfunction

        function void close_run();
            if (run_state == RUN_ONE)
                emit_code_point(prev_cp, prev_len, 1'b1);
            run_state = RUN_EMPTY;
            prev_cp   = 32'd0;
            prev_len  = 3'd0;
        endfunction

        function void finish_code_point();
            if (run_state == RUN_EMPTY)
                run_state = RUN_ONE;
            else
            begin
                emit_code_point(prev_cp, prev_len, 1'b0);
                emit_code_point(cur_cp, cur_len, 1'b1);
                run_state = RUN_MANY;
            end
            prev_cp      = cur_cp;
            prev_len     = cur_len;
            cur_cp       = 32'd0;
            cur_len      = 3'd0;
            pending_cont = 3'd0;
        endfunction

        function void note_text_byte(logic [7:0] b, logic eot);
            logic        word_char;
            logic [7:0]  folded;
            token_word_t w;
            int          i;
            burst.delete();
            word_char = ((b >= CHAR_0) && (b <= CHAR_9)) ||
                        ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) ||
                        ((b >= CHAR_LO_A) && (b <= CHAR_LO_Z));
            folded = ((b >= CHAR_UP_A) && (b <= CHAR_UP_Z)) ? b + CASE_OFFSET : b;
            if (pending_cont != 3'd0)
            begin
                cur_cp       = (cur_cp << 8) | {24'd0, b};
                cur_len      = cur_len + 3'd1;
                pending_cont = pending_cont - 3'd1;
                if (pending_cont == 3'd0)
                    finish_code_point();
            end
            else if (b < HIGH_BIT_MASK)
            begin
                if (word_char)
                begin
                    close_run();
                    if (word_state != WORD_NONE)
                    begin
                        emit(held_byte, 1'b0);
                        word_state = WORD_MANY;
                    end
                    else
                        word_state = WORD_ONE;
                    held_byte = folded;
                end
                else
                begin
                    close_word();
                    close_run();
                end
            end
            else
            begin
                close_word();
                cur_cp  = {24'd0, b};
                cur_len = 3'd1;
                if ((b & LEAD2_MASK) == LEAD2_CODE)
                    pending_cont = 3'd1;
                else if ((b & LEAD3_MASK) == LEAD3_CODE)
                    pending_cont = 3'd2;
                else if ((b & LEAD4_MASK) == LEAD4_CODE)
                    pending_cont = 3'd3;
                else
                    pending_cont = 3'd0;
                if (pending_cont == 3'd0)
                    finish_code_point();
            end
            if (eot)
            begin
                if (pending_cont != 3'd0)
                    finish_code_point();
                close_word();
                close_run();
                clear_state();
            end
            for (i = 0; i < burst.size(); i++)
            begin
                w            = burst[i];
                w.burst_last = (i == burst.size() - 1);
                expected_words.insert(expected_words.size(), w);
            end
        endfunction

        function void check_token_word(logic [7:0] data, logic token_end, logic burst_last);
            token_word_t exp_w;
            if (expected_words.size() == 0)
            begin
                failures++;
                $display("%0t: unexpected word: expected none, got data=%h end=%b last=%b",
                         $time, data, token_end, burst_last);
            end
            else
            begin
                exp_w = expected_words.pop_front();
                if (data !== exp_w.data || token_end !== exp_w.token_end ||
                    burst_last !== exp_w.burst_last)
                begin
                    failures++;
                    $display("%0t: word mismatch: expected data=%h end=%b last=%b, got data=%h end=%b last=%b",
                             $time, exp_w.data, exp_w.token_end, exp_w.burst_last,
                             data, token_end, burst_last);
                end
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    token_stream_scoreboard sb;
    logic       no_idle = 1'b0;
    int         idle_cycles = 0;
    logic [7:0] text_buf[$];
    logic [7:0] directed_text[$] = '{8'h41, 8'h7A, 8'h30, 8'h20, 8'h78, 8'h80, 8'hFF, 8'hC3,
                                     8'hA9, 8'hE4, 8'h61, 8'h00, 8'hF0, 8'h9F, 8'h98, 8'h80,
                                     8'h39, 8'h51, 8'h7F, 8'hE2, 8'h82, 8'hF7, 8'h4D, 8'h39};
    logic [7:0] separators[$] = '{8'h00, 8'h09, 8'h0A, 8'h20, 8'h21, 8'h2C, 8'h2E, 8'h2F,
                                  8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7F};

    utf8_word_and_bigram_tokenizer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : drain_tokens
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 4);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            sb.check_token_word(m_tdata, m_tlast, m_tuser);
        end
    end

    task automatic send_text_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_text_byte(b, eot);
    endtask

    function automatic logic [7:0] pick_cont_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    task automatic make_random_text();
        int         pieces;
        int         k;
        int         j;
        int         n;
        int         r;
        int         cp_kind;
        text_buf.delete();
        pieces = $urandom_range(1, 6);
        for (k = 0; k < pieces; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
            begin
                n = $urandom_range(1, 5);
                for (j = 0; j < n; j++)
                begin
                    r = $urandom_range(0, 61);
                    if (r < 10)
                        text_buf.insert(text_buf.size(), CHAR_0 + 8'(r));
                    else if (r < 36)
                        text_buf.insert(text_buf.size(), CHAR_UP_A + 8'(r - 10));
                    else
                        text_buf.insert(text_buf.size(), CHAR_LO_A + 8'(r - 36));
                end
            end
            else if (r < 7)
            begin
                n = $urandom_range(1, 4);
                for (j = 0; j < n; j++)
                begin
                    cp_kind = $urandom_range(0, 3);
                    case (cp_kind)
                        0:
                        begin
                            if ($urandom_range(0, 1) == 0)
                                text_buf.insert(text_buf.size(),
                                                8'($urandom_range(8'hBF, 8'h80)));
                            else
                                text_buf.insert(text_buf.size(),
                                                8'($urandom_range(8'hFF, 8'hF8)));
                        end
                        1:
                        begin
                            text_buf.insert(text_buf.size(), 8'($urandom_range(8'hDF, 8'hC0)));
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                        end
                        2:
                        begin
                            text_buf.insert(text_buf.size(), 8'($urandom_range(8'hEF, 8'hE0)));
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                        end
                        default:
                        begin
                            text_buf.insert(text_buf.size(), 8'($urandom_range(8'hF7, 8'hF0)));
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                            text_buf.insert(text_buf.size(), pick_cont_byte());
                        end
                    endcase
                end
            end
            else if (r < 9)
                text_buf.insert(text_buf.size(),
                                separators[$urandom_range(0, separators.size() - 1)]);
            else
                text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 5) == 0 && text_buf.size() > 1)
            text_buf.delete(text_buf.size() - 1);
    endtask

    initial
    begin : stimulus
        int random_sent;
        int i;
        sb          = new();
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tlast     = 1'b0;
        random_sent = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < directed_text.size(); i++)
            send_text_byte(directed_text[i], DIRECTED_EOT[i]);

        while (random_sent < RANDOM_BYTES)
        begin
            make_random_text();
            no_idle = ($urandom_range(0, 4) == 0);
            for (i = 0; i < text_buf.size(); i++)
                send_text_byte(text_buf[i], i == text_buf.size() - 1);
            random_sent += text_buf.size();
        end
        no_idle = 1'b0;

        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.failures == 0 && sb.expected_words.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
